### hdl/rbf_pkg.sv
// shared types, constants and helper functions for the rgb box filter
`timescale 1ns / 1ps

package rbf_pkg;

    // elaboration defaults for the top level parameters
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // configuration port
    localparam int CFG_W            = 12;
    localparam int CFG_IDX_W        = 1;
    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // pixel and result formats
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 11;
    localparam int SUM_W  = 12;

    // divide by 9 as multiply by reciprocal, exact for sums up to 9*255
    localparam int                DIV9_W     = 13;
    localparam logic [DIV9_W-1:0] DIV9_MUL   = 13'd7282;
    localparam int                DIV9_SHIFT = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    localparam int RGB_W = $bits(rgb_t);

    typedef struct packed {
        logic do_avg;
        logic do_border;
    } pix_kind_t;

    localparam int KIND_W = $bits(pix_kind_t);

    typedef struct packed {
        logic [PIX_W-1:0] pix_col;
        logic [PIX_W-1:0] pix_row;
        rgb_t             pix;
        logic             is_averaged;
        logic             last_of_run;
    } res_t;

    function automatic logic [SUM_W-1:0] add3(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] c
    );
        return SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    endfunction

    function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+DIV9_W-1:0] p;
        p = (SUM_W+DIV9_W)'(s) * (SUM_W+DIV9_W)'(DIV9_MUL);
        return p[DIV9_SHIFT+CHAN_W-1:DIV9_SHIFT];
    endfunction

endpackage

### hdl/rbf_front.sv
// front end: configuration registers, raster counters and pixel classification
`timescale 1ns / 1ps

module rbf_front
    import rbf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rgb_t                          in_pix,
    input  logic                          q_full,
    output logic                          q_push,
    output rgb_t                          q_pix,
    output logic [$clog2(MAX_WIDTH)-1:0]  q_x,
    output logic [$clog2(MAX_HEIGHT)-1:0] q_y,
    output pix_kind_t                     q_kind
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CW-1:0]    w_last;
    logic [RW-1:0]    h_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_W'(DEF_IMAGE_WIDTH);
            image_height_reg <= CFG_W'(DEF_IMAGE_HEIGHT);
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // last column / row index in use, zero taken as one, clipped to the maximum
    always_comb
    begin
        if (image_width_reg == '0)
            w_last = '0;
        else if (32'(image_width_reg) > MAX_WIDTH)
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(image_width_reg - CFG_W'(1));

        if (image_height_reg == '0)
            h_last = '0;
        else if (32'(image_height_reg) > MAX_HEIGHT)
            h_last = RW'(MAX_HEIGHT - 1);
        else
            h_last = RW'(image_height_reg - CFG_W'(1));
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_pix    = in_pix;
    assign q_x      = col_reg;
    assign q_y      = row_reg;

    always_comb
    begin
        q_kind.do_avg    = (col_reg >= CW'(2)) && (row_reg >= RW'(2));
        q_kind.do_border = (col_reg == '0) || (row_reg == '0) ||
                           (col_reg >= w_last) || (row_reg >= h_last);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push)
        begin
            if (col_reg >= w_last)
            begin
                col_next = '0;
                row_next = (row_reg >= h_last) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### hdl/rbf_fifo.sv
// small first-in first-out queue between front and back
`timescale 1ns / 1ps

module rbf_fifo
    import rbf_pkg::*;
#(
    parameter int WIDTH = RGB_W,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (cnt_reg == NW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + NW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### hdl/rbf_back.sv
// back end: line stores, 3x3 window, channel sums, divide by nine, result words
`timescale 1ns / 1ps

module rbf_back
    import rbf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  rgb_t                          q_pix,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0] q_y,
    input  pix_kind_t                     q_kind,
    output logic                          out_valid,
    input  logic                          out_ready,
    output res_t                          out_word
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // line stores, no reset
    rgb_t mem_prev  [MAX_WIDTH];
    rgb_t mem_prev2 [MAX_WIDTH];

    // stage a: popped item and line store read data
    logic          a_valid_reg;
    rgb_t          a_pix_reg;
    logic [CW-1:0] a_x_reg;
    logic [RW-1:0] a_y_reg;
    pix_kind_t     a_kind_reg;
    rgb_t          rd_prev_reg;
    rgb_t          rd_prev2_reg;

    // window: [row][age], row 0 oldest line, age 0 oldest column
    rgb_t win_reg [3][2];
    rgb_t col [3];

    // stage b: registered channel sums
    logic             b_valid_reg;
    logic [SUM_W-1:0] b_sum_r_reg, b_sum_g_reg, b_sum_b_reg;
    rgb_t             b_pix_reg;
    logic [CW-1:0]    b_x_reg;
    logic [RW-1:0]    b_y_reg;
    pix_kind_t        b_kind_reg;

    // stage c: up to two result words
    logic c_valid_reg;
    logic c_two_reg;
    logic c_sel_reg;
    res_t c_word0_reg;
    res_t c_word1_reg;

    logic             c_done;
    logic             adv;
    logic             wr_en;
    logic             fwd;
    logic [SUM_W-1:0] row_r [3];
    logic [SUM_W-1:0] row_g [3];
    logic [SUM_W-1:0] row_b [3];
    logic [SUM_W-1:0] sum_r, sum_g, sum_b;
    res_t             avg_word;
    res_t             border_word;

    // whole back pipeline moves when the output stage can take a new pair
    assign c_done = c_valid_reg && out_ready && (!c_two_reg || c_sel_reg);
    assign adv    = !c_valid_reg || c_done;
    assign q_pop  = adv && !q_empty;
    assign wr_en  = adv && a_valid_reg;
    // the read of the next item hits the entry being written this cycle
    assign fwd    = wr_en && (q_x == a_x_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_prev[a_x_reg]  <= a_pix_reg;
            mem_prev2[a_x_reg] <= rd_prev_reg;
        end
        if (q_pop)
        begin
            rd_prev_reg  <= fwd ? a_pix_reg   : mem_prev[q_x];
            rd_prev2_reg <= fwd ? rd_prev_reg : mem_prev2[q_x];
            a_pix_reg    <= q_pix;
            a_x_reg      <= q_x;
            a_y_reg      <= q_y;
            a_kind_reg   <= q_kind;
        end
    end

    assign col[0] = rd_prev2_reg;
    assign col[1] = rd_prev_reg;
    assign col[2] = a_pix_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_r[r] = add3(win_reg[r][0].r, win_reg[r][1].r, col[r].r);
            row_g[r] = add3(win_reg[r][0].g, win_reg[r][1].g, col[r].g);
            row_b[r] = add3(win_reg[r][0].b, win_reg[r][1].b, col[r].b);
        end
        sum_r = row_r[0] + row_r[1] + row_r[2];
        sum_g = row_g[0] + row_g[1] + row_g[2];
        sum_b = row_b[0] + row_b[1] + row_b[2];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= col[r];
            end
            b_sum_r_reg <= sum_r;
            b_sum_g_reg <= sum_g;
            b_sum_b_reg <= sum_b;
            b_pix_reg   <= a_pix_reg;
            b_x_reg     <= a_x_reg;
            b_y_reg     <= a_y_reg;
            b_kind_reg  <= a_kind_reg;
        end
    end

    always_comb
    begin
        avg_word.pix_col     = PIX_W'(b_x_reg - CW'(1));
        avg_word.pix_row     = PIX_W'(b_y_reg - RW'(1));
        avg_word.pix.r       = div9(b_sum_r_reg);
        avg_word.pix.g       = div9(b_sum_g_reg);
        avg_word.pix.b       = div9(b_sum_b_reg);
        avg_word.is_averaged = 1'b1;
        avg_word.last_of_run = !b_kind_reg.do_border;

        border_word.pix_col     = PIX_W'(b_x_reg);
        border_word.pix_row     = PIX_W'(b_y_reg);
        border_word.pix         = b_pix_reg;
        border_word.is_averaged = 1'b0;
        border_word.last_of_run = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_word0_reg <= b_kind_reg.do_avg ? avg_word : border_word;
            c_word1_reg <= border_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            c_two_reg   <= 1'b0;
            c_sel_reg   <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= !q_empty;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg && (b_kind_reg.do_avg || b_kind_reg.do_border);
            c_two_reg   <= b_valid_reg && b_kind_reg.do_avg && b_kind_reg.do_border;
            c_sel_reg   <= 1'b0;
        end
        else if (c_valid_reg && out_ready && c_two_reg && !c_sel_reg)
        begin
            c_sel_reg <= 1'b1;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_word  = c_sel_reg ? c_word1_reg : c_word0_reg;

endmodule

### hdl/rgb_box_filter_3x3_top.sv
// top level of the 3x3 rgb box filter: front, queue and back end
`timescale 1ns / 1ps

// channel   dir  handshake                     word contents
// cfg       in   cfg_valid / cfg_ready         cfg_index (0 width, 1 height), cfg_data
// s_axis    in   s_axis_tvalid / s_axis_tready one raster-order rgb pixel
// m_axis    out  m_axis_tvalid / m_axis_tready one result pixel with coordinates
//
// one pixel per clock while the queue has room; its first result word is offered once it
// has passed the queue, line store read, channel sum and divided result word registers
// a pixel with both an averaged word and a border copy holds the back end until both go out;
// once four are banked in the queue each one stalls the input (rows 2 and on
// at the right edge, last row from column 2); m_axis back-pressure stalls the back end
// reset clears counters and valid bits and loads 640 x 480; line stores keep contents

module rgb_box_filter_3x3_top
    import rbf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // red_in [7:0], green_in [15:8], blue_in [23:16]
    input  logic [23:0]          s_axis_tdata,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pix_col [10:0], pix_row [21:11], red_out [29:22], green_out [37:30],
    // blue_out [45:38], zero [47:46]
    output logic [47:0]          m_axis_tdata,
    // is_averaged
    output logic                 m_axis_tuser,
    // last_of_run
    output logic                 m_axis_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int EW = RGB_W + CW + RW + KIND_W;

    rgb_t          in_pix;
    logic          q_full;
    logic          q_push;
    rgb_t          f_pix;
    logic [CW-1:0] f_x;
    logic [RW-1:0] f_y;
    pix_kind_t     f_kind;
    logic [EW-1:0] push_data;
    logic [EW-1:0] pop_data;
    logic          q_pop;
    logic          q_empty;
    res_t          out_word;

    assign in_pix.r = s_axis_tdata[7:0];
    assign in_pix.g = s_axis_tdata[15:8];
    assign in_pix.b = s_axis_tdata[23:16];

    rbf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_pix    (in_pix),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_pix     (f_pix),
        .q_x       (f_x),
        .q_y       (f_y),
        .q_kind    (f_kind)
    );

    // queue word: pixel lowest, then column, row and kind flags
    assign push_data = {f_kind, f_y, f_x, f_pix};

    rbf_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    rbf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_pix     (rgb_t'(pop_data[RGB_W-1:0])),
        .q_x       (pop_data[RGB_W+CW-1:RGB_W]),
        .q_y       (pop_data[RGB_W+CW+RW-1:RGB_W+CW]),
        .q_kind    (pix_kind_t'(pop_data[EW-1:RGB_W+CW+RW])),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {2'b00, out_word.pix.b, out_word.pix.g, out_word.pix.r,
                           out_word.pix_row, out_word.pix_col};
    assign m_axis_tuser = out_word.is_averaged;
    assign m_axis_tlast = out_word.last_of_run;

endmodule

### sim/tb_rgb_box_filter_3x3_top.sv
// testbench for the 3x3 rgb box filter: directed and random frames checked against a running prediction
`timescale 1ns / 1ps

// tracks the filter state and holds the result words still to come
class box_mean_tracker;
    rbf_pkg::rgb_t   above1 [rbf_pkg::DEF_MAX_WIDTH];
    rbf_pkg::rgb_t   above2 [rbf_pkg::DEF_MAX_WIDTH];
    rbf_pkg::rgb_t   win [3][2];
    rbf_pkg::res_t   due_words [$];
    logic [rbf_pkg::CFG_W-1:0] width_reg;
    logic [rbf_pkg::CFG_W-1:0] height_reg;
    int              col_cnt;
    int              row_cnt;
    int              bad_words;

    function new();
        foreach (above1[i])
        begin
            above1[i] = '0;
            above2[i] = '0;
        end
        foreach (win[r, a])
            win[r][a] = '0;
        width_reg  = rbf_pkg::CFG_W'(rbf_pkg::DEF_IMAGE_WIDTH);
        height_reg = rbf_pkg::CFG_W'(rbf_pkg::DEF_IMAGE_HEIGHT);
        col_cnt    = 0;
        row_cnt    = 0;
        bad_words  = 0;
    endfunction

    function void set_reg(rbf_pkg::cfg_reg_t idx, logic [rbf_pkg::CFG_W-1:0] v);
        if (idx == rbf_pkg::REG_IMAGE_WIDTH)
            width_reg = v;
        else
            height_reg = v;
    endfunction

    // zero counts as one, anything past the store size saturates
    function int frame_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > rbf_pkg::DEF_MAX_WIDTH)
            return rbf_pkg::DEF_MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function int frame_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > rbf_pkg::DEF_MAX_HEIGHT)
            return rbf_pkg::DEF_MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    function int words_due();
        return due_words.size();
    endfunction

    // one accepted pixel: predict the averaged word and/or the border copy it causes
    function void take_pixel(logic [23:0] word);
        rbf_pkg::rgb_t cur;
        rbf_pkg::rgb_t column [3];
        rbf_pkg::res_t outs [2];
        int            n;
        int            x;
        int            y;
        int            w;
        int            h;
        int            sum_r;
        int            sum_g;
        int            sum_b;

        cur.r     = word[7:0];
        cur.g     = word[15:8];
        cur.b     = word[23:16];
        w         = frame_width();
        h         = frame_height();
        x         = col_cnt;
        y         = row_cnt;
        column[0] = above2[x];
        column[1] = above1[x];
        column[2] = cur;
        n         = 0;

        if (x >= 2 && y >= 2)
        begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int r = 0; r < 3; r++)
            begin
                sum_r += win[r][0].r + win[r][1].r + column[r].r;
                sum_g += win[r][0].g + win[r][1].g + column[r].g;
                sum_b += win[r][0].b + win[r][1].b + column[r].b;
            end
            outs[n].pix_col     = rbf_pkg::PIX_W'(x - 1);
            outs[n].pix_row     = rbf_pkg::PIX_W'(y - 1);
            outs[n].pix.r       = rbf_pkg::CHAN_W'(sum_r / 9);
            outs[n].pix.g       = rbf_pkg::CHAN_W'(sum_g / 9);
            outs[n].pix.b       = rbf_pkg::CHAN_W'(sum_b / 9);
            outs[n].is_averaged = 1'b1;
            outs[n].last_of_run = 1'b0;
            n++;
        end

        if (x == 0 || y == 0 || x + 1 >= w || y + 1 >= h)
        begin
            outs[n].pix_col     = rbf_pkg::PIX_W'(x);
            outs[n].pix_row     = rbf_pkg::PIX_W'(y);
            outs[n].pix         = cur;
            outs[n].is_averaged = 1'b0;
            outs[n].last_of_run = 1'b0;
            n++;
        end

        if (n > 0)
            outs[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            due_words.push_back(outs[i]);

        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = column[r];
        end
        above2[x] = above1[x];
        above1[x] = cur;

        if (x + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (y + 1 >= h) ? 0 : y + 1;
        end
        else
            col_cnt = x + 1;
    endfunction

    // one accepted result word against the oldest one due
    function void match_result(logic [47:0] word, logic avg, logic last);
        rbf_pkg::res_t got;
        rbf_pkg::res_t want;

        got.pix_col     = word[10:0];
        got.pix_row     = word[21:11];
        got.pix.r       = word[29:22];
        got.pix.g       = word[37:30];
        got.pix.b       = word[45:38];
        got.is_averaged = avg;
        got.last_of_run = last;

        if (due_words.size() == 0)
        begin
            if (bad_words < 10)
                $display("result with nothing due: col %0d row %0d rgb %02h %02h %02h avg %0b last %0b",
                         got.pix_col, got.pix_row, got.pix.r, got.pix.g, got.pix.b,
                         got.is_averaged, got.last_of_run);
            bad_words++;
            return;
        end

        want = due_words.pop_front();
        if (got.pix_col != want.pix_col || got.pix_row != want.pix_row ||
            got.pix.r != want.pix.r || got.pix.g != want.pix.g ||
            got.pix.b != want.pix.b || got.is_averaged != want.is_averaged ||
            got.last_of_run != want.last_of_run || word[47:46] != 2'b00)
        begin
            if (bad_words < 10)
            begin
                $display("mismatch expected: col %0d row %0d rgb %02h %02h %02h avg %0b last %0b",
                         want.pix_col, want.pix_row, want.pix.r, want.pix.g, want.pix.b,
                         want.is_averaged, want.last_of_run);
                $display("         actual:   col %0d row %0d rgb %02h %02h %02h avg %0b last %0b pad %0b",
                         got.pix_col, got.pix_row, got.pix.r, got.pix.g, got.pix.b,
                         got.is_averaged, got.last_of_run, word[47:46]);
            end
            bad_words++;
        end
    endfunction
endclass

module tb_rgb_box_filter_3x3_top;
    import rbf_pkg::*;

    // cycles with no word moving on any channel before the run is given up
    localparam int STALL_LIMIT = 5000;
    // long back-pressure hold on the result side
    localparam int HOLD_CYCLES = 300;
    // settle time after the last result word
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PIXELS = 800;

    typedef enum {FILL_RANDOM, FILL_WHITE, FILL_BLACK} fill_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    // both sides run without random gaps while quiet is set; a requested hold still applies
    bit                   quiet    = 1'b0;
    // asks the result side for one long hold
    bit                   hold_req = 1'b0;
    int                   idle_cycles = 0;
    int                   random_sent = 0;
    int                   fail_total;

    box_mean_tracker      tracker = new();

    rgb_box_filter_3x3_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // all inputs change only on the rising edge, so the values seen at the
    // falling edge are the ones the next rising edge will act on
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // watchdog on progress
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, none while quiet, one long hold on request
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= 37);
        end
    end

    function automatic logic [7:0] rand_chan();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // offer one pixel word, with a random gap first, and wait until it is taken
    task automatic send_pixel(input logic [23:0] word);
        bit taken;
        while (!quiet && $urandom_range(99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        forever
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
            if (taken)
                break;
        end
    endtask

    // register write; the caller lowers cfg_valid after the last one
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        forever
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
            if (taken)
                break;
        end
        tracker.set_reg(idx, v);
    endtask

    // wait for the block to drain, load new frame size, then stream whole frames
    // so that the counters are back at zero before any later register change
    task automatic run_phase(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                             input int frames, input fill_t fill, input bit calm,
                             input bit squeeze);
        int          pixels;
        logic [23:0] word;

        s_axis_tvalid <= 1'b0;
        while (tracker.words_due() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        write_reg(REG_IMAGE_WIDTH, w_val);
        write_reg(REG_IMAGE_HEIGHT, h_val);
        cfg_valid <= 1'b0;

        quiet = calm;
        if (squeeze)
            hold_req = 1'b1;
        pixels = frames * tracker.frame_width() * tracker.frame_height();
        for (int i = 0; i < pixels; i++)
        begin
            case (fill)
                FILL_WHITE: word = 24'hFFFFFF;
                FILL_BLACK: word = 24'h000000;
                default:    word = {rand_chan(), rand_chan(), rand_chan()};
            endcase
            send_pixel(word);
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        int          w_pick;
        int          h_pick;
        int          w_val;
        int          h_val;
        int          frames;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: saturated sums, zero sums, plain frames
        run_phase(12'd3, 12'd3, 1, FILL_WHITE, 1'b0, 1'b0);
        run_phase(12'd3, 12'd3, 1, FILL_BLACK, 1'b0, 1'b0);
        run_phase(12'd4, 12'd4, 2, FILL_RANDOM, 1'b0, 1'b0);
        // zero size is taken as one pixel, so every frame is a single border copy
        run_phase(12'd0, 12'd0, 3, FILL_RANDOM, 1'b0, 1'b0);
        // frames too narrow or too short to hold any interior pixel
        run_phase(12'd2, 12'd3, 1, FILL_RANDOM, 1'b0, 1'b0);
        run_phase(12'd5, 12'd2, 1, FILL_RANDOM, 1'b0, 1'b0);
        run_phase(12'd1, 12'd1, 2, FILL_RANDOM, 1'b0, 1'b0);
        // wide rows streamed without gaps while the result side holds off
        // so the input backs up
        run_phase(12'd40, 12'd3, 1, FILL_RANDOM, 1'b1, 1'b1);

        // random part: mostly small frames, a few narrow or wide ones
        while (random_sent < RANDOM_PIXELS)
        begin
            w_pick = $urandom_range(9);
            h_pick = $urandom_range(9);
            if (w_pick == 0)
                w_val = $urandom_range(1, 2);
            else if (w_pick == 1)
                w_val = $urandom_range(13, 64);
            else
                w_val = $urandom_range(3, 12);
            if (h_pick == 0)
                h_val = $urandom_range(1, 2);
            else if (h_pick == 1)
                h_val = $urandom_range(9, 16);
            else
                h_val = $urandom_range(3, 8);
            frames = $urandom_range(1, 2);
            run_phase(CFG_W'(w_val), CFG_W'(h_val), frames, FILL_RANDOM,
                      $urandom_range(5) == 0, random_sent == 0);
            random_sent += frames * w_val * h_val;
        end

        // drain and let any stray word show up
        s_axis_tvalid <= 1'b0;
        while (tracker.words_due() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        fail_total = tracker.bad_words + tracker.words_due();
        if (tracker.words_due() != 0)
            $display("%0d result words never arrived", tracker.words_due());
        if (fail_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hdl/rbf_pkg.sv
hdl/rbf_front.sv
hdl/rbf_fifo.sv
hdl/rbf_back.sv
hdl/rgb_box_filter_3x3_top.sv
sim/tb_rgb_box_filter_3x3_top.sv
